// ----- src/mips32_instruction_execute_assert.svh -----
// Assertion macros used by the controller of the MIPS32 execute core.
`ifndef MIPS32_INSTRUCTION_EXECUTE_ASSERT_SVH
`define MIPS32_INSTRUCTION_EXECUTE_ASSERT_SVH
`ifndef SYNTH
`define MIE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define MIE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define MIE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MIE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- src/mips_ie_pkg.sv -----
// Package of types, codes and constants for the MIPS32 execute core.
`default_nettype none
package mips_ie_pkg;

	localparam int unsigned XLEN      = 32;
	localparam int unsigned NUM_REGS  = 32;
	localparam int unsigned DIV_STEPS = 32;

	// Item opcodes.
	localparam logic [1:0] ITEM_EXEC = 2'd0;
	localparam logic [1:0] ITEM_LOAD = 2'd1;
	localparam logic [1:0] ITEM_BOOT = 2'd2;
	localparam logic [1:0] ITEM_NOP  = 2'd3;

	// Access kinds.
	localparam logic [1:0] ACC_NONE  = 2'd0;
	localparam logic [1:0] ACC_READ  = 2'd1;
	localparam logic [1:0] ACC_WRITE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_START = 2'd0;
	localparam logic [1:0] CFG_GP    = 2'd1;
	localparam logic [1:0] CFG_SP    = 2'd2;

	// Fixed register numbers.
	localparam logic [4:0] REG_V0 = 5'd2;
	localparam logic [4:0] REG_GP = 5'd28;
	localparam logic [4:0] REG_SP = 5'd29;
	localparam logic [4:0] REG_RA = 5'd31;

	// Primary opcodes.
	localparam logic [5:0] OPC_SPECIAL = 6'h00;
	localparam logic [5:0] OPC_REGIMM  = 6'h01;
	localparam logic [5:0] OPC_J       = 6'h02;
	localparam logic [5:0] OPC_JAL     = 6'h03;
	localparam logic [5:0] OPC_BEQ     = 6'h04;
	localparam logic [5:0] OPC_BNE     = 6'h05;
	localparam logic [5:0] OPC_BLEZ    = 6'h06;
	localparam logic [5:0] OPC_BGTZ    = 6'h07;
	localparam logic [5:0] OPC_ADDI    = 6'h08;
	localparam logic [5:0] OPC_ADDIU   = 6'h09;
	localparam logic [5:0] OPC_SLTI    = 6'h0A;
	localparam logic [5:0] OPC_SLTIU   = 6'h0B;
	localparam logic [5:0] OPC_ANDI    = 6'h0C;
	localparam logic [5:0] OPC_ORI     = 6'h0D;
	localparam logic [5:0] OPC_XORI    = 6'h0E;
	localparam logic [5:0] OPC_LUI     = 6'h0F;
	localparam logic [5:0] OPC_BEQL    = 6'h14;
	localparam logic [5:0] OPC_BNEL    = 6'h15;
	localparam logic [5:0] OPC_BLEZL   = 6'h16;
	localparam logic [5:0] OPC_LB      = 6'h20;
	localparam logic [5:0] OPC_LH      = 6'h21;
	localparam logic [5:0] OPC_LWL     = 6'h22;
	localparam logic [5:0] OPC_LW      = 6'h23;
	localparam logic [5:0] OPC_LBU     = 6'h24;
	localparam logic [5:0] OPC_LHU     = 6'h25;
	localparam logic [5:0] OPC_LWR     = 6'h26;
	localparam logic [5:0] OPC_SB      = 6'h28;
	localparam logic [5:0] OPC_SH      = 6'h29;
	localparam logic [5:0] OPC_SWL     = 6'h2A;
	localparam logic [5:0] OPC_SW      = 6'h2B;
	localparam logic [5:0] OPC_SWR     = 6'h2E;

	// Function codes of the special group.
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_SLLV    = 6'h04;
	localparam logic [5:0] FN_SRLV    = 6'h06;
	localparam logic [5:0] FN_SRAV    = 6'h07;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MTHI    = 6'h11;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MTLO    = 6'h13;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_DIVU    = 6'h1B;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;
	localparam logic [5:0] FN_SLTU    = 6'h2B;

	// Register-immediate branch codes (rt field).
	localparam logic [4:0] RI_BLTZ   = 5'h00;
	localparam logic [4:0] RI_BGEZ   = 5'h01;
	localparam logic [4:0] RI_BLTZAL = 5'h10;
	localparam logic [4:0] RI_BGEZAL = 5'h11;

	// Pending load kinds.
	localparam logic [2:0] LK_NONE = 3'd0;
	localparam logic [2:0] LK_LB   = 3'd1;
	localparam logic [2:0] LK_LH   = 3'd2;
	localparam logic [2:0] LK_LWL  = 3'd3;
	localparam logic [2:0] LK_LW   = 3'd4;
	localparam logic [2:0] LK_LBU  = 3'd5;
	localparam logic [2:0] LK_LHU  = 3'd6;
	localparam logic [2:0] LK_LWR  = 3'd7;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] instruction_word;
		logic [31:0] load_word;
	} item_t;

	typedef struct packed {
		logic [31:0] fetch_address;
		logic [1:0]  access_kind;
		logic [31:0] access_address;
		logic [31:0] store_data;
		logic [3:0]  byte_lanes;
		logic        load_pending;
		logic        reg_written;
		logic [4:0]  reg_number;
		logic [31:0] reg_value;
		logic        service_request;
		logic [31:0] service_code;
	} result_t;

	typedef struct packed {
		logic       capture;
		logic       read;
		logic       exec;
		logic       div_step;
		logic       div_fix;
		logic       boot_clr;
		logic       boot_wr;
		logic [1:0] boot_sel;
		logic       publish;
	} cmd_t;

	typedef struct packed {
		logic boot;
		logic div_go;
	} sts_t;

endpackage
`default_nettype wire

// ----- src/mips_ie_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module mips_ie_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end
endmodule
`default_nettype wire

// ----- src/mips_ie_datapath.sv -----
// Datapath: register file, HI/LO, program counter, execute logic and divider.
`default_nettype none
module mips_ie_datapath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mips_ie_pkg::item_t    item,
	input  wire mips_ie_pkg::cmd_t     cmd,
	output mips_ie_pkg::sts_t          sts,
	input  wire logic [31:0]           cfg_start,
	input  wire logic [31:0]           cfg_gp,
	input  wire logic [31:0]           cfg_sp,
	output mips_ie_pkg::result_t       result
);
	localparam int unsigned RAW = $clog2(mips_ie_pkg::NUM_REGS);

	mips_ie_pkg::item_t   item_q;
	mips_ie_pkg::result_t res_q;
	mips_ie_pkg::result_t out_q;

	logic [mips_ie_pkg::NUM_REGS-1:0] valid_q;
	logic        va_q, vb_q;
	logic [31:0] hi_q, lo_q, pc_q, bt_q;
	logic [2:0]  dc_q;
	logic [9:0]  pl_q;

	// Divider registers.
	logic [31:0] dq_q, dr_q, dd_q;
	logic        qneg_q, rneg_q;

	logic [31:0] ins, rd_a, rd_b, a, b, imm, simm, cur, nxt, tgt, vaddr, ld_w, old;
	logic [5:0]  opc, fn;
	logic [4:0]  rs, rt, rd, sh, pl_rt;
	logic [1:0]  o, po;
	logic [2:0]  pl_kind, dc_t, dc_s;
	logic [4:0]  sa3, psa3, po8, o8;
	logic        pend, is_exec, is_ret, take, sx;
	logic [RAW-1:0] raddr_a, raddr_b, waddr;
	logic        we;
	logic [31:0] wdata;

	logic        x_put;
	logic [4:0]  x_num;
	logic [31:0] x_val, x_addr, x_data, x_code, hi_n, lo_n;
	logic [1:0]  x_kind;
	logic [3:0]  x_lanes;
	logic        x_svc, div_go;
	logic [9:0]  pl_n;
	logic [65:0] prod;
	logic [7:0]  byt;
	logic [15:0] half;

	logic [32:0] dv_sh, dv_diff;

	assign ins   = item_q.instruction_word;
	assign opc   = ins[31:26];
	assign rs    = ins[25:21];
	assign rt    = ins[20:16];
	assign rd    = ins[15:11];
	assign sh    = ins[10:6];
	assign fn    = ins[5:0];
	assign imm   = {16'd0, ins[15:0]};
	assign simm  = {{16{ins[15]}}, ins[15:0]};
	assign pend  = (pl_q != 10'd0);
	assign is_exec = (item_q.opcode == mips_ie_pkg::ITEM_EXEC) && !pend;
	assign is_ret  = (item_q.opcode == mips_ie_pkg::ITEM_LOAD) && pend;
	assign pl_kind = pl_q[9:7];
	assign pl_rt   = pl_q[6:2];
	assign po      = pl_q[1:0];

	// Port A reads register 2 for a service call, otherwise rs.
	assign raddr_a = (opc == mips_ie_pkg::OPC_SPECIAL && fn == mips_ie_pkg::FN_SYSCALL)
		? mips_ie_pkg::REG_V0 : rs;
	assign raddr_b = is_ret ? pl_rt : rt;

	always_comb begin
		case (cmd.boot_sel)
			2'd0:    begin waddr = mips_ie_pkg::REG_GP; wdata = cfg_gp; end
			2'd1:    begin waddr = mips_ie_pkg::REG_SP; wdata = cfg_sp; end
			default: begin waddr = mips_ie_pkg::REG_RA; wdata = cfg_start; end
		endcase
		if (!cmd.boot_wr) begin
			waddr = x_num;
			wdata = x_val;
		end
	end
	assign we = cmd.boot_wr || (cmd.exec && x_put);

	mips_ie_ram #(
		.WIDTH(mips_ie_pkg::XLEN),
		.DEPTH(mips_ie_pkg::NUM_REGS)
	) u_gpr (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(cmd.read), .raddr_a(raddr_a), .raddr_b(raddr_b),
		.rdata_a(rd_a), .rdata_b(rd_b)
	);

	// Entries never written since boot read as zero.
	assign a = va_q ? rd_a : 32'd0;
	assign b = vb_q ? rd_b : 32'd0;
	assign old = b;

	assign cur   = pc_q;
	assign vaddr = a + simm;
	assign o     = vaddr[1:0];
	assign o8    = {o, 3'b000};
	assign sa3   = {2'd3 - o, 3'b000};
	assign po8   = {po, 3'b000};
	assign psa3  = {2'd3 - po, 3'b000};
	assign ld_w  = item_q.load_word;
	assign sx    = (fn == mips_ie_pkg::FN_MULT);
	assign prod  = $signed({sx & a[31], a}) * $signed({sx & b[31], b});
	assign byt   = 8'(ld_w >> psa3);
	assign half  = po[1] ? ld_w[15:0] : ld_w[31:16];

	always_comb begin
		x_put = 1'b0; x_num = rd; x_val = 32'd0;
		x_kind = mips_ie_pkg::ACC_NONE; x_addr = 32'd0; x_data = 32'd0; x_lanes = 4'd0;
		x_svc = 1'b0; x_code = 32'd0;
		take = 1'b0; tgt = cur + 32'd4 + {simm[29:0], 2'b00}; nxt = cur + 32'd4;
		hi_n = hi_q; lo_n = lo_q; pl_n = pl_q; div_go = 1'b0;
		if (is_ret) begin
			x_put = 1'b1; x_num = pl_rt; pl_n = 10'd0;
			case (pl_kind)
				mips_ie_pkg::LK_LB:  x_val = {{24{byt[7]}}, byt};
				mips_ie_pkg::LK_LBU: x_val = {24'd0, byt};
				mips_ie_pkg::LK_LH:  x_val = {{16{half[15]}}, half};
				mips_ie_pkg::LK_LHU: x_val = {16'd0, half};
				mips_ie_pkg::LK_LW:  x_val = ld_w;
				mips_ie_pkg::LK_LWL: x_val = (ld_w << po8) | (old & ~(32'hFFFFFFFF << po8));
				default:             x_val = (ld_w >> psa3) | (old & ~(32'hFFFFFFFF >> psa3));
			endcase
		end else if (is_exec) begin
			case (opc)
				mips_ie_pkg::OPC_SPECIAL: begin
					case (fn)
						mips_ie_pkg::FN_SLL:  begin x_put = 1'b1; x_val = b << sh; end
						mips_ie_pkg::FN_SRL:  begin x_put = 1'b1; x_val = b >> sh; end
						mips_ie_pkg::FN_SRA:  begin x_put = 1'b1; x_val = 32'($signed(b) >>> sh); end
						mips_ie_pkg::FN_SLLV: begin x_put = 1'b1; x_val = b << a[4:0]; end
						mips_ie_pkg::FN_SRLV: begin x_put = 1'b1; x_val = b >> a[4:0]; end
						mips_ie_pkg::FN_SRAV: begin
							x_put = 1'b1; x_val = 32'($signed(b) >>> a[4:0]);
						end
						mips_ie_pkg::FN_JR:   begin take = 1'b1; tgt = a; end
						mips_ie_pkg::FN_JALR: begin
							take = 1'b1; tgt = a; x_put = 1'b1; x_val = cur + 32'd8;
						end
						mips_ie_pkg::FN_SYSCALL: begin x_svc = 1'b1; x_code = a; end
						mips_ie_pkg::FN_MFHI: begin x_put = 1'b1; x_val = hi_q; end
						mips_ie_pkg::FN_MTHI: hi_n = a;
						mips_ie_pkg::FN_MFLO: begin x_put = 1'b1; x_val = lo_q; end
						mips_ie_pkg::FN_MTLO: lo_n = a;
						mips_ie_pkg::FN_MULT, mips_ie_pkg::FN_MULTU: begin
							lo_n = prod[31:0]; hi_n = prod[63:32];
						end
						mips_ie_pkg::FN_DIV, mips_ie_pkg::FN_DIVU: begin
							if (b == 32'd0) begin
								lo_n = 32'hFFFFFFFF; hi_n = a;
							end else begin
								div_go = 1'b1;
							end
						end
						mips_ie_pkg::FN_ADD, mips_ie_pkg::FN_ADDU: begin
							x_put = 1'b1; x_val = a + b;
						end
						mips_ie_pkg::FN_SUB, mips_ie_pkg::FN_SUBU: begin
							x_put = 1'b1; x_val = a - b;
						end
						mips_ie_pkg::FN_AND: begin x_put = 1'b1; x_val = a & b; end
						mips_ie_pkg::FN_OR:  begin x_put = 1'b1; x_val = a | b; end
						mips_ie_pkg::FN_XOR: begin x_put = 1'b1; x_val = a ^ b; end
						mips_ie_pkg::FN_NOR: begin x_put = 1'b1; x_val = ~(a | b); end
						mips_ie_pkg::FN_SLT: begin
							x_put = 1'b1; x_val = {31'd0, $signed(a) < $signed(b)};
						end
						mips_ie_pkg::FN_SLTU: begin x_put = 1'b1; x_val = {31'd0, a < b}; end
						default: ;
					endcase
				end
				mips_ie_pkg::OPC_REGIMM: begin
					case (rt)
						mips_ie_pkg::RI_BLTZ: take = a[31];
						mips_ie_pkg::RI_BGEZ: take = !a[31];
						mips_ie_pkg::RI_BLTZAL: begin
							take = a[31]; x_put = 1'b1; x_num = mips_ie_pkg::REG_RA;
							x_val = cur + 32'd8;
						end
						mips_ie_pkg::RI_BGEZAL: begin
							take = !a[31]; x_put = 1'b1; x_num = mips_ie_pkg::REG_RA;
							x_val = cur + 32'd8;
						end
						default: ;
					endcase
				end
				mips_ie_pkg::OPC_J, mips_ie_pkg::OPC_JAL: begin
					take = 1'b1;
					tgt = {nxt[31:28], ins[25:0], 2'b00};
					if (opc == mips_ie_pkg::OPC_JAL) begin
						x_put = 1'b1; x_num = mips_ie_pkg::REG_RA; x_val = cur + 32'd8;
					end
				end
				mips_ie_pkg::OPC_BEQ:  take = (a == b);
				mips_ie_pkg::OPC_BNE:  take = (a != b);
				mips_ie_pkg::OPC_BLEZ: take = ($signed(a) <= 0);
				mips_ie_pkg::OPC_BGTZ: take = ($signed(a) > 0);
				mips_ie_pkg::OPC_BEQL: begin
					take = (a == b); if (!take) nxt = cur + 32'd8;
				end
				mips_ie_pkg::OPC_BNEL: begin
					take = (a != b); if (!take) nxt = cur + 32'd8;
				end
				mips_ie_pkg::OPC_BLEZL: begin
					take = ($signed(a) <= 0); if (!take) nxt = cur + 32'd8;
				end
				mips_ie_pkg::OPC_ADDI, mips_ie_pkg::OPC_ADDIU: begin
					x_put = 1'b1; x_num = rt; x_val = a + simm;
				end
				mips_ie_pkg::OPC_SLTI: begin
					x_put = 1'b1; x_num = rt; x_val = {31'd0, $signed(a) < $signed(simm)};
				end
				mips_ie_pkg::OPC_SLTIU: begin
					x_put = 1'b1; x_num = rt; x_val = {31'd0, a < simm};
				end
				mips_ie_pkg::OPC_ANDI: begin x_put = 1'b1; x_num = rt; x_val = a & imm; end
				mips_ie_pkg::OPC_ORI:  begin x_put = 1'b1; x_num = rt; x_val = a | imm; end
				mips_ie_pkg::OPC_XORI: begin x_put = 1'b1; x_num = rt; x_val = a ^ imm; end
				mips_ie_pkg::OPC_LUI:  begin x_put = 1'b1; x_num = rt; x_val = {imm[15:0], 16'd0}; end
				mips_ie_pkg::OPC_LB, mips_ie_pkg::OPC_LH, mips_ie_pkg::OPC_LWL,
				mips_ie_pkg::OPC_LW, mips_ie_pkg::OPC_LBU, mips_ie_pkg::OPC_LHU,
				mips_ie_pkg::OPC_LWR: begin
					x_kind = mips_ie_pkg::ACC_READ; x_addr = {vaddr[31:2], 2'b00};
					pl_n = {3'(opc[2:0] + 3'd1), rt, o};
				end
				mips_ie_pkg::OPC_SB: begin
					x_kind = mips_ie_pkg::ACC_WRITE; x_addr = {vaddr[31:2], 2'b00};
					x_data = {24'd0, b[7:0]} << sa3; x_lanes = 4'b1000 >> o;
				end
				mips_ie_pkg::OPC_SH: begin
					x_kind = mips_ie_pkg::ACC_WRITE; x_addr = {vaddr[31:2], 2'b00};
					x_data = o[1] ? {16'd0, b[15:0]} : {b[15:0], 16'd0};
					x_lanes = o[1] ? 4'b0011 : 4'b1100;
				end
				mips_ie_pkg::OPC_SW: begin
					x_kind = mips_ie_pkg::ACC_WRITE; x_addr = {vaddr[31:2], 2'b00};
					x_data = b; x_lanes = 4'b1111;
				end
				mips_ie_pkg::OPC_SWL: begin
					x_kind = mips_ie_pkg::ACC_WRITE; x_addr = {vaddr[31:2], 2'b00};
					x_data = b >> o8; x_lanes = 4'b1111 >> o;
				end
				mips_ie_pkg::OPC_SWR: begin
					x_kind = mips_ie_pkg::ACC_WRITE; x_addr = {vaddr[31:2], 2'b00};
					x_data = b << sa3; x_lanes = 4'b1111 << (2'd3 - o);
				end
				default: ;
			endcase
		end
		// Writes to register zero are dropped and reported as no write.
		if (!x_put || x_num == 5'd0) begin
			x_put = 1'b0; x_num = 5'd0; x_val = 32'd0;
		end
	end

	// Branch delay: a taken branch loads four, halved per instruction.
	assign dc_t = take ? 3'd4 : dc_q;
	assign dc_s = dc_t >> 1;

	assign sts.boot   = (item_q.opcode == mips_ie_pkg::ITEM_BOOT);
	assign sts.div_go = div_go;

	// One restoring division step per cycle on magnitudes.
	assign dv_sh   = {dr_q, dq_q[31]};
	assign dv_diff = dv_sh - {1'b0, dd_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.read) begin
			va_q <= valid_q[raddr_a];
			vb_q <= valid_q[raddr_b];
		end
		if (cmd.capture) begin
			res_q <= '0;
		end else if (cmd.exec) begin
			res_q.access_kind     <= x_kind;
			res_q.access_address  <= x_addr;
			res_q.store_data      <= x_data;
			res_q.byte_lanes      <= x_lanes;
			res_q.reg_written     <= x_put;
			res_q.reg_number      <= x_num;
			res_q.reg_value       <= x_val;
			res_q.service_request <= x_svc;
			res_q.service_code    <= x_code;
		end
		if (cmd.exec && div_go) begin
			qneg_q <= (fn == mips_ie_pkg::FN_DIV) && (a[31] != b[31]);
			rneg_q <= (fn == mips_ie_pkg::FN_DIV) && a[31];
			dq_q   <= ((fn == mips_ie_pkg::FN_DIV) && a[31]) ? 32'd0 - a : a;
			dd_q   <= ((fn == mips_ie_pkg::FN_DIV) && b[31]) ? 32'd0 - b : b;
			dr_q   <= 32'd0;
		end else if (cmd.div_step) begin
			dq_q <= {dq_q[30:0], !dv_diff[32]};
			dr_q <= dv_diff[32] ? dv_sh[31:0] : dv_diff[31:0];
		end
		if (cmd.publish) begin
			out_q <= res_q;
			out_q.fetch_address <= pc_q;
			out_q.load_pending  <= pend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hi_q <= 32'd0; lo_q <= 32'd0; pc_q <= 32'd0; bt_q <= 32'd0;
			dc_q <= 3'd0; pl_q <= 10'd0;
		end else begin
			if (cmd.boot_clr) begin
				valid_q <= '0;
				hi_q <= 32'd0; lo_q <= 32'd0; bt_q <= 32'd0;
				dc_q <= 3'd0; pl_q <= 10'd0; pc_q <= cfg_start;
			end
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (cmd.exec) begin
				hi_q <= hi_n;
				lo_q <= lo_n;
				pl_q <= pl_n;
				if (is_exec) begin
					if (take) begin
						bt_q <= tgt;
					end
					if (dc_s == 3'd1) begin
						pc_q <= bt_q;
						dc_q <= 3'd0;
					end else begin
						pc_q <= nxt;
						dc_q <= dc_s;
					end
				end
			end
			if (cmd.div_fix) begin
				lo_q <= qneg_q ? 32'd0 - dq_q : dq_q;
				hi_q <= rneg_q ? 32'd0 - dr_q : dr_q;
			end
		end
	end

	assign result = out_q;
endmodule
`default_nettype wire

// ----- src/mips_ie_ctrl.sv -----
// Controller state machine that sequences each item through the datapath.
`default_nettype none
`include "mips32_instruction_execute_assert.svh"
module mips_ie_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	output logic                   result_valid,
	input  wire logic              result_ready,
	input  wire mips_ie_pkg::sts_t sts,
	output mips_ie_pkg::cmd_t      cmd
);
	localparam int unsigned CW = $clog2(mips_ie_pkg::DIV_STEPS);
	localparam logic [CW-1:0] CNT_LAST = CW'(mips_ie_pkg::DIV_STEPS - 1);
	localparam logic [CW-1:0] BOOT_LAST = CW'(2);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_EX   = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DFIX = 3'd4;
	localparam logic [2:0] ST_BOOT = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          accept;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = accept;
		cmd.read     = (state_q == ST_RD);
		cmd.exec     = (state_q == ST_EX);
		cmd.div_step = (state_q == ST_DIV);
		cmd.div_fix  = (state_q == ST_DFIX);
		cmd.boot_clr = (state_q == ST_BOOT) && (cnt_q == '0);
		cmd.boot_wr  = (state_q == ST_BOOT);
		cmd.boot_sel = cnt_q[1:0];
		cmd.publish  = (state_q == ST_FIN) && (!out_valid_q || result_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_RD;
			ST_RD:   state_d = sts.boot ? ST_BOOT : ST_EX;
			ST_EX:   state_d = sts.div_go ? ST_DIV : ST_FIN;
			ST_DIV:  if (cnt_q == CNT_LAST) state_d = ST_DFIX;
			ST_DFIX: state_d = ST_FIN;
			ST_BOOT: if (cnt_q == BOOT_LAST) state_d = ST_FIN;
			ST_FIN:  if (cmd.publish) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV || state_q == ST_BOOT) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`MIE_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, state_q == ST_RD, "accepted item did not start")
	`MIE_ASSERT_NXT(a_publish_valid, clk, arst_n, cmd.publish, out_valid_q, "published result not offered")
	`MIE_ASSERT_IMP(a_div_count, clk, arst_n, state_q == ST_DFIX, $past(cnt_q) == CNT_LAST, "divide left early")
endmodule
`default_nettype wire

// ----- src/mips32_instruction_execute.sv -----
// An accepted item passes through the idle, register read, execute and output steps before its
// result is offered; a divide adds the one-bit-per-cycle divider and a sign fix, and a boot
// takes its three register writes in place of the execute step.
// Items are not overlapped: a new item is accepted only after the last result is loaded.
// Reset: arst_n clears all architectural state, the configuration and the controller.
// The register file reads as zero after reset and after each boot until written.
`default_nettype none
module mips32_instruction_execute (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Input channel: one transfer per item.
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire mips_ie_pkg::item_t   item,
	// Result channel: one transfer per item.
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output mips_ie_pkg::result_t      result,
	// Configuration port.
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready
);
	mips_ie_pkg::cmd_t cmd;
	mips_ie_pkg::sts_t sts;

	logic [31:0] start_q, gp_q, sp_q;
	logic        cfg_wr;

	// A configuration transfer completes in its access cycle; there are no wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 32'd0;
			gp_q    <= 32'd0;
			sp_q    <= 32'd0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				mips_ie_pkg::CFG_START: start_q <= pwdata;
				mips_ie_pkg::CFG_GP:    gp_q    <= pwdata;
				mips_ie_pkg::CFG_SP:    sp_q    <= pwdata;
				default: ;
			endcase
		end
	end

	// Reads return the register at the addressed word; the unused slot reads zero.
	always_comb begin
		case (paddr[3:2])
			mips_ie_pkg::CFG_START: prdata = start_q;
			mips_ie_pkg::CFG_GP:    prdata = gp_q;
			mips_ie_pkg::CFG_SP:    prdata = sp_q;
			default:                prdata = 32'd0;
		endcase
	end

	// The controller steps every item through register read, then execute or the boot writes,
	// with the divider after execute where needed, then loads the output register.
	mips_ie_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.result_valid(result_valid), .result_ready(result_ready),
		.sts(sts), .cmd(cmd)
	);

	// The datapath holds all architectural state and the output register.
	mips_ie_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .cmd(cmd), .sts(sts),
		.cfg_start(start_q), .cfg_gp(gp_q), .cfg_sp(sp_q), .result(result)
	);
endmodule
`default_nettype wire

// ----- verif/tb_mips32_instruction_execute.sv -----
// Self-checking testbench of the MIPS32 execute core with its own instruction-level predictor.
`default_nettype none
module tb_mips32_instruction_execute;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 900000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	mips_ie_pkg::item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	mips_ie_pkg::result_t result;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	mips32_instruction_execute DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Architectural state of the predicted core.
	logic [31:0] cfg_start, cfg_gp, cfg_sp;
	logic [31:0] gpr [32];
	logic [31:0] hi_q, lo_q, pc_q, btgt_q;
	logic [2:0]  dly_q;
	logic [2:0]  ld_kind;
	logic [4:0]  ld_reg;
	logic [1:0]  ld_off;

	mips_ie_pkg::result_t expected_results [$];
	int mismatches = 0;
	int cycles = 0;
	int results_seen = 0;
	int load_count = 0, store_count = 0, branch_count = 0;
	bit idle_enable = 1'b1;
	mips_ie_pkg::result_t pr;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h (result %0d)", what, got, want, results_seen);
		mismatches++;
	endtask

	function automatic void wreg(input logic [4:0] n, input logic [31:0] v);
		if (n != 5'd0) begin
			gpr[n] = v;
			pr.reg_written = 1'b1;
			pr.reg_number = n;
			pr.reg_value = v;
		end
	endfunction

	function automatic logic slt_s(input logic [31:0] a, input logic [31:0] b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic void complete_load(input logic [31:0] w);
		logic [31:0] old, v;
		logic [7:0] bt;
		logic [15:0] hw;
		old = gpr[ld_reg];
		bt = w >> (24 - 8 * ld_off);
		hw = w >> (16 - 8 * (ld_off & 2'd2));
		case (ld_kind)
			mips_ie_pkg::LK_LB:  v = {{24{bt[7]}}, bt};
			mips_ie_pkg::LK_LBU: v = {24'd0, bt};
			mips_ie_pkg::LK_LH:  v = {{16{hw[15]}}, hw};
			mips_ie_pkg::LK_LHU: v = {16'd0, hw};
			mips_ie_pkg::LK_LW:  v = w;
			mips_ie_pkg::LK_LWL:
				v = (w << (8 * ld_off)) | (old & ((32'd1 << (8 * ld_off)) - 32'd1));
			default:
				v = (w >> (8 * (3 - ld_off))) | (old & ~(32'hFFFFFFFF >> (8 * (3 - ld_off))));
		endcase
		ld_kind = mips_ie_pkg::LK_NONE;
		wreg(ld_reg, v);
	endfunction

	function automatic void run_instruction(input logic [31:0] ins);
		logic [31:0] cur, nxt, imm, simm, a, b, bt, va, q, r, ua, ub;
		logic [5:0] opc, fn;
		logic [4:0] rs, rt, rd, sh;
		logic [1:0] o;
		logic [63:0] p;
		logic take;
		cur = pc_q; nxt = cur + 4;
		opc = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
		sh = ins[10:6]; fn = ins[5:0];
		imm = {16'd0, ins[15:0]}; simm = {{16{ins[15]}}, ins[15:0]};
		a = gpr[rs]; b = gpr[rt];
		bt = cur + 4 + (simm << 2);
		va = a + simm; o = va[1:0];
		take = 1'b0;
		if (opc == mips_ie_pkg::OPC_SPECIAL) begin
			case (fn)
				mips_ie_pkg::FN_SLL:  wreg(rd, b << sh);
				mips_ie_pkg::FN_SRL:  wreg(rd, b >> sh);
				mips_ie_pkg::FN_SRA:  wreg(rd, $signed(b) >>> sh);
				mips_ie_pkg::FN_SLLV: wreg(rd, b << a[4:0]);
				mips_ie_pkg::FN_SRLV: wreg(rd, b >> a[4:0]);
				mips_ie_pkg::FN_SRAV: wreg(rd, $signed(b) >>> a[4:0]);
				mips_ie_pkg::FN_JR:   begin take = 1'b1; bt = a; end
				mips_ie_pkg::FN_JALR: begin take = 1'b1; bt = a; wreg(rd, cur + 8); end
				mips_ie_pkg::FN_SYSCALL: begin
					pr.service_request = 1'b1; pr.service_code = gpr[mips_ie_pkg::REG_V0];
				end
				mips_ie_pkg::FN_MFHI: wreg(rd, hi_q);
				mips_ie_pkg::FN_MTHI: hi_q = a;
				mips_ie_pkg::FN_MFLO: wreg(rd, lo_q);
				mips_ie_pkg::FN_MTLO: lo_q = a;
				mips_ie_pkg::FN_MULT: begin
					p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
					lo_q = p[31:0]; hi_q = p[63:32];
				end
				mips_ie_pkg::FN_MULTU: begin
					p = {32'd0, a} * {32'd0, b};
					lo_q = p[31:0]; hi_q = p[63:32];
				end
				mips_ie_pkg::FN_DIV, mips_ie_pkg::FN_DIVU: begin
					if (b == 0) begin
						lo_q = 32'hFFFFFFFF; hi_q = a;
					end else if (fn == mips_ie_pkg::FN_DIVU) begin
						lo_q = a / b; hi_q = a % b;
					end else begin
						ua = a[31] ? -a : a;
						ub = b[31] ? -b : b;
						q = ua / ub; r = ua % ub;
						lo_q = (a[31] != b[31]) ? -q : q;
						hi_q = a[31] ? -r : r;
					end
				end
				mips_ie_pkg::FN_ADD, mips_ie_pkg::FN_ADDU: wreg(rd, a + b);
				mips_ie_pkg::FN_SUB, mips_ie_pkg::FN_SUBU: wreg(rd, a - b);
				mips_ie_pkg::FN_AND: wreg(rd, a & b);
				mips_ie_pkg::FN_OR:  wreg(rd, a | b);
				mips_ie_pkg::FN_XOR: wreg(rd, a ^ b);
				mips_ie_pkg::FN_NOR: wreg(rd, ~(a | b));
				mips_ie_pkg::FN_SLT: wreg(rd, {31'd0, slt_s(a, b)});
				mips_ie_pkg::FN_SLTU: wreg(rd, {31'd0, a < b});
				default: ;
			endcase
		end else if (opc == mips_ie_pkg::OPC_REGIMM) begin
			case (rt)
				mips_ie_pkg::RI_BLTZ: take = a[31];
				mips_ie_pkg::RI_BGEZ: take = !a[31];
				mips_ie_pkg::RI_BLTZAL: begin
					take = a[31]; wreg(mips_ie_pkg::REG_RA, cur + 8);
				end
				mips_ie_pkg::RI_BGEZAL: begin
					take = !a[31]; wreg(mips_ie_pkg::REG_RA, cur + 8);
				end
				default: ;
			endcase
		end else begin
			case (opc)
				mips_ie_pkg::OPC_J, mips_ie_pkg::OPC_JAL: begin
					take = 1'b1;
					bt = ((cur + 4) & 32'hF0000000) | ((ins & 32'h03FFFFFF) << 2);
					if (opc == mips_ie_pkg::OPC_JAL) wreg(mips_ie_pkg::REG_RA, cur + 8);
				end
				mips_ie_pkg::OPC_BEQ:  take = (a == b);
				mips_ie_pkg::OPC_BNE:  take = (a != b);
				mips_ie_pkg::OPC_BLEZ: take = !slt_s(0, a);
				mips_ie_pkg::OPC_BGTZ: take = slt_s(0, a);
				// Branch-likely not taken skips its delay slot.
				mips_ie_pkg::OPC_BEQL: begin take = (a == b); if (!take) nxt = cur + 8; end
				mips_ie_pkg::OPC_BNEL: begin take = (a != b); if (!take) nxt = cur + 8; end
				mips_ie_pkg::OPC_BLEZL: begin
					take = !slt_s(0, a); if (!take) nxt = cur + 8;
				end
				mips_ie_pkg::OPC_ADDI, mips_ie_pkg::OPC_ADDIU: wreg(rt, a + simm);
				mips_ie_pkg::OPC_SLTI:  wreg(rt, {31'd0, slt_s(a, simm)});
				mips_ie_pkg::OPC_SLTIU: wreg(rt, {31'd0, a < simm});
				mips_ie_pkg::OPC_ANDI:  wreg(rt, a & imm);
				mips_ie_pkg::OPC_ORI:   wreg(rt, a | imm);
				mips_ie_pkg::OPC_XORI:  wreg(rt, a ^ imm);
				mips_ie_pkg::OPC_LUI:   wreg(rt, imm << 16);
				mips_ie_pkg::OPC_LB, mips_ie_pkg::OPC_LH, mips_ie_pkg::OPC_LWL,
				mips_ie_pkg::OPC_LW, mips_ie_pkg::OPC_LBU, mips_ie_pkg::OPC_LHU,
				mips_ie_pkg::OPC_LWR: begin
					pr.access_kind = mips_ie_pkg::ACC_READ;
					pr.access_address = va & 32'hFFFFFFFC;
					ld_kind = 3'(opc - 6'h1F);
					ld_reg = rt; ld_off = o;
				end
				mips_ie_pkg::OPC_SB, mips_ie_pkg::OPC_SH, mips_ie_pkg::OPC_SWL,
				mips_ie_pkg::OPC_SW, mips_ie_pkg::OPC_SWR: begin
					pr.access_kind = mips_ie_pkg::ACC_WRITE;
					pr.access_address = va & 32'hFFFFFFFC;
					case (opc)
						mips_ie_pkg::OPC_SB: begin
							pr.store_data = (b & 32'hFF) << (24 - 8 * o);
							pr.byte_lanes = 4'd8 >> o;
						end
						mips_ie_pkg::OPC_SH: begin
							pr.store_data = (b & 32'hFFFF) << (16 - 8 * (o & 2'd2));
							pr.byte_lanes = o[1] ? 4'd3 : 4'd12;
						end
						mips_ie_pkg::OPC_SW: begin
							pr.store_data = b; pr.byte_lanes = 4'd15;
						end
						mips_ie_pkg::OPC_SWL: begin
							pr.store_data = b >> (8 * o); pr.byte_lanes = 4'd15 >> o;
						end
						default: begin
							pr.store_data = b << (8 * (3 - o));
							pr.byte_lanes = 4'(8'd15 << (3 - o));
						end
					endcase
				end
				default: ;
			endcase
		end
		if (take) begin btgt_q = bt; dly_q = 3'd4; end
		pc_q = nxt;
		dly_q = dly_q >> 1;
		if (dly_q == 3'd1) begin pc_q = btgt_q; dly_q = 3'd0; end
	endfunction

	function automatic void predict_core(input mips_ie_pkg::item_t it);
		pr = '0;
		if (it.opcode == mips_ie_pkg::ITEM_BOOT) begin
			foreach (gpr[i]) gpr[i] = '0;
			hi_q = '0; lo_q = '0; dly_q = '0; ld_kind = mips_ie_pkg::LK_NONE; btgt_q = '0;
			gpr[mips_ie_pkg::REG_GP] = cfg_gp;
			gpr[mips_ie_pkg::REG_SP] = cfg_sp;
			gpr[mips_ie_pkg::REG_RA] = cfg_start;
			pc_q = cfg_start;
		end else if (it.opcode == mips_ie_pkg::ITEM_LOAD) begin
			if (ld_kind != mips_ie_pkg::LK_NONE) complete_load(it.load_word);
		end else if (it.opcode == mips_ie_pkg::ITEM_EXEC) begin
			if (ld_kind == mips_ie_pkg::LK_NONE) run_instruction(it.instruction_word);
		end
		pr.fetch_address = pc_q;
		pr.load_pending = (ld_kind != mips_ie_pkg::LK_NONE);
		expected_results.push_back(pr);
	endfunction

	// One transfer on the item channel, with an optional random gap first.
	// Valid stays high after the transfer until the next gap or a drain.
	task automatic send_item(input mips_ie_pkg::item_t it);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		predict_core(it);
		@(negedge clk);
	endtask

	task automatic release_item();
		item_valid <= 1'b0;
	endtask

	task automatic exec_ins(input logic [31:0] ins);
		mips_ie_pkg::item_t it;
		it.opcode = mips_ie_pkg::ITEM_EXEC; it.instruction_word = ins; it.load_word = $urandom;
		send_item(it);
	endtask

	// If a load was issued, the data return follows.
	task automatic serve_load();
		mips_ie_pkg::item_t it;
		if (ld_kind != mips_ie_pkg::LK_NONE) begin
			it.opcode = mips_ie_pkg::ITEM_LOAD;
			it.instruction_word = $urandom; it.load_word = $urandom;
			send_item(it);
			load_count++;
		end
	endtask

	task automatic boot();
		mips_ie_pkg::item_t it;
		it.opcode = mips_ie_pkg::ITEM_BOOT;
		it.instruction_word = $urandom; it.load_word = $urandom;
		send_item(it);
	endtask

	task automatic wait_drain();
		release_item();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			mips_ie_pkg::CFG_START: cfg_start = v;
			mips_ie_pkg::CFG_GP: cfg_gp = v;
			default: cfg_sp = v;
		endcase
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic [31:0] s, input logic [31:0] g, input logic [31:0] p);
		wait_drain();
		cfg_write(mips_ie_pkg::CFG_START, s);
		cfg_write(mips_ie_pkg::CFG_GP, g);
		cfg_write(mips_ie_pkg::CFG_SP, p);
	endtask

	function automatic logic [31:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
		input logic [4:0] rd, input logic [4:0] sh, input logic [5:0] fn);
		return {mips_ie_pkg::OPC_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
		input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] rand_ins();
		logic [5:0] opl [31];
		logic [5:0] fnl [27];
		logic [31:0] w;
		opl = '{mips_ie_pkg::OPC_SPECIAL, mips_ie_pkg::OPC_REGIMM, mips_ie_pkg::OPC_J,
			mips_ie_pkg::OPC_JAL, mips_ie_pkg::OPC_BEQ, mips_ie_pkg::OPC_BNE,
			mips_ie_pkg::OPC_BLEZ, mips_ie_pkg::OPC_BGTZ, mips_ie_pkg::OPC_ADDI,
			mips_ie_pkg::OPC_ADDIU, mips_ie_pkg::OPC_SLTI, mips_ie_pkg::OPC_SLTIU,
			mips_ie_pkg::OPC_ANDI, mips_ie_pkg::OPC_ORI, mips_ie_pkg::OPC_XORI,
			mips_ie_pkg::OPC_LUI, mips_ie_pkg::OPC_BEQL, mips_ie_pkg::OPC_BNEL,
			mips_ie_pkg::OPC_BLEZL, mips_ie_pkg::OPC_LB, mips_ie_pkg::OPC_LH,
			mips_ie_pkg::OPC_LWL, mips_ie_pkg::OPC_LW, mips_ie_pkg::OPC_LBU,
			mips_ie_pkg::OPC_LHU, mips_ie_pkg::OPC_LWR, mips_ie_pkg::OPC_SB,
			mips_ie_pkg::OPC_SH, mips_ie_pkg::OPC_SWL, mips_ie_pkg::OPC_SW,
			mips_ie_pkg::OPC_SWR};
		fnl = '{mips_ie_pkg::FN_SLL, mips_ie_pkg::FN_SRL, mips_ie_pkg::FN_SRA,
			mips_ie_pkg::FN_SLLV, mips_ie_pkg::FN_SRLV, mips_ie_pkg::FN_SRAV,
			mips_ie_pkg::FN_JR, mips_ie_pkg::FN_JALR, mips_ie_pkg::FN_SYSCALL,
			mips_ie_pkg::FN_MFHI, mips_ie_pkg::FN_MTHI, mips_ie_pkg::FN_MFLO,
			mips_ie_pkg::FN_MTLO, mips_ie_pkg::FN_MULT, mips_ie_pkg::FN_MULTU,
			mips_ie_pkg::FN_DIV, mips_ie_pkg::FN_DIVU, mips_ie_pkg::FN_ADD,
			mips_ie_pkg::FN_ADDU, mips_ie_pkg::FN_SUB, mips_ie_pkg::FN_SUBU,
			mips_ie_pkg::FN_AND, mips_ie_pkg::FN_OR, mips_ie_pkg::FN_XOR,
			mips_ie_pkg::FN_NOR, mips_ie_pkg::FN_SLT, mips_ie_pkg::FN_SLTU};
		w = $urandom;
		case ($urandom_range(0, 19))
			0: ;
			1, 2, 3, 4, 5, 6: w = {mips_ie_pkg::OPC_SPECIAL, w[25:6], fnl[$urandom_range(0, 26)]};
			7: w = {mips_ie_pkg::OPC_REGIMM, w[25:21],
				($urandom_range(0, 1) ? mips_ie_pkg::RI_BLTZAL : mips_ie_pkg::RI_BLTZ)
				| 5'($urandom_range(0, 1)), w[15:0]};
			default: w[31:26] = opl[$urandom_range(0, 30)];
		endcase
		// Mostly small register numbers so values flow between instructions.
		if ($urandom_range(0, 3) != 0) begin
			w[25:21] = $urandom_range(0, 7);
			w[20:16] = $urandom_range(0, 7);
			w[15:11] = $urandom_range(0, 7);
		end
		return w;
	endfunction

	// Result side: random stalls, check against the oldest expectation.
	always @(negedge clk)
		if (idle_enable && $urandom_range(0, 7) == 0)
			result_ready <= 1'b0;
		else if (!result_ready || !idle_enable || $urandom_range(0, 3) == 0)
			result_ready <= (!idle_enable) || ($urandom_range(0, 2) != 0);

	always @(posedge clk) begin
		mips_ie_pkg::result_t e;
		cycles++;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report("unexpected result", result.fetch_address, 32'd0);
			end else begin
				e = expected_results.pop_front();
				if (result.fetch_address !== e.fetch_address)
					report("fetch_address", result.fetch_address, e.fetch_address);
				if (result.access_kind !== e.access_kind)
					report("access_kind", result.access_kind, e.access_kind);
				if (result.access_address !== e.access_address)
					report("access_address", result.access_address, e.access_address);
				if (result.store_data !== e.store_data)
					report("store_data", result.store_data, e.store_data);
				if (result.byte_lanes !== e.byte_lanes)
					report("byte_lanes", result.byte_lanes, e.byte_lanes);
				if (result.load_pending !== e.load_pending)
					report("load_pending", result.load_pending, e.load_pending);
				if (result.reg_written !== e.reg_written)
					report("reg_written", result.reg_written, e.reg_written);
				if (result.reg_number !== e.reg_number)
					report("reg_number", result.reg_number, e.reg_number);
				if (result.reg_value !== e.reg_value)
					report("reg_value", result.reg_value, e.reg_value);
				if (result.service_request !== e.service_request)
					report("service_request", result.service_request, e.service_request);
				if (result.service_code !== e.service_code)
					report("service_code", result.service_code, e.service_code);
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Extremes of arithmetic, shift, memory and jump instructions, with stall and ignore cases.
	task automatic test_directed();
		mips_ie_pkg::item_t it;
		configure(32'h0000_1000, 32'hFFFF_FFFF, 32'h8000_0000);
		boot();
		exec_ins(itype(mips_ie_pkg::OPC_LUI, 0, 1, 16'h8000));
		exec_ins(itype(mips_ie_pkg::OPC_ADDI, 0, 2, 16'hFFFF));
		exec_ins(rtype(1, 2, 3, 0, mips_ie_pkg::FN_ADD));
		exec_ins(rtype(1, 2, 0, 0, mips_ie_pkg::FN_SUB));
		exec_ins(rtype(1, 2, 0, 0, mips_ie_pkg::FN_DIV));
		exec_ins(rtype(1, 0, 0, 0, mips_ie_pkg::FN_DIVU));
		exec_ins(rtype(0, 0, 4, 0, mips_ie_pkg::FN_MFHI));
		exec_ins(rtype(0, 0, 5, 0, mips_ie_pkg::FN_MFLO));
		exec_ins(rtype(1, 2, 0, 0, mips_ie_pkg::FN_MULT));
		exec_ins(itype(mips_ie_pkg::OPC_SLTIU, 1, 6, 16'hFFFF));
		exec_ins(rtype(0, 1, 7, 5'd31, mips_ie_pkg::FN_SRA));
		exec_ins(rtype(0, 0, 0, 0, mips_ie_pkg::FN_SYSCALL));
		exec_ins(itype(mips_ie_pkg::OPC_LH, 29, 8, 16'h0003));
		exec_ins(rtype(1, 1, 1, 0, mips_ie_pkg::FN_ADD));
		it.opcode = mips_ie_pkg::ITEM_NOP; it.instruction_word = '1; it.load_word = '1;
		send_item(it);
		serve_load();
		it.opcode = mips_ie_pkg::ITEM_LOAD;
		send_item(it);
		exec_ins(itype(mips_ie_pkg::OPC_SWR, 28, 2, 16'h0001));
		exec_ins(itype(mips_ie_pkg::OPC_BNEL, 0, 0, 16'h7FFF));
		exec_ins(itype(mips_ie_pkg::OPC_BEQ, 0, 0, 16'h8000));
		exec_ins({mips_ie_pkg::OPC_J, 26'h3FF_FFFF});
		exec_ins(rtype(31, 0, 9, 0, mips_ie_pkg::FN_JALR));
	endtask

	// Random programs with load returns, occasional noise and boots.
	task automatic test_random(input int count);
		mips_ie_pkg::item_t it;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) == 0) begin
				boot();
			end else if ($urandom_range(0, 49) == 0) begin
				it.opcode = 2'($urandom_range(1, 3));
				it.instruction_word = $urandom; it.load_word = $urandom;
				send_item(it);
			end else begin
				exec_ins(rand_ins());
				if (expected_results[$].access_kind == mips_ie_pkg::ACC_WRITE) store_count++;
				if (dly_q != 0) branch_count++;
				if ($urandom_range(0, 9) == 0) exec_ins(rand_ins());
				serve_load();
			end
		end
	endtask

	initial begin
		cfg_start = '0; cfg_gp = '0; cfg_sp = '0;
		foreach (gpr[i]) gpr[i] = '0;
		hi_q = '0; lo_q = '0; pc_q = '0; btgt_q = '0; dly_q = '0;
		ld_kind = mips_ie_pkg::LK_NONE; ld_reg = '0; ld_off = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		configure(32'h0, 32'h0, 32'h0);
		boot();
		test_random(350);
		// Hold the sender until every expected result has come.
		wait_drain();
		configure(32'hFFFF_FFFC, 32'h1234_5678, 32'h7FFF_FFF0);
		boot();
		test_random(350);
		configure($urandom, $urandom, $urandom);
		boot();
		idle_enable = 1'b0;
		test_random(350);
		release_item();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		$display("covered %0d results, %0d load returns, %0d stores, %0d branches",
			results_seen, load_count, store_count, branch_count);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire
